// ===== sv/assert_macros.svh =====
// Assertion macros used by the power mode controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BPM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bpm_pkg.sv =====
// Types, codes and constants of the battery and idle power mode controller.
package bpm_pkg;

   localparam int FUNC_W     = 2;
   localparam int SMP_W      = 13;
   localparam int MV_W       = 12;
   localparam int PCT_W      = 7;
   localparam int CNT_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // millivolts = sample * 3600 / 4096
   localparam int ADC_SHIFT  = 12;
   localparam int PROD_W     = 24;
   localparam int MV_SCALE   = 3600;

   // percent divider: numerator below 100 * 4096, quotient below 128
   localparam int PCT_FULL   = 100;
   localparam int NUM_W      = 19;
   localparam int QUO_W      = 7;
   localparam int STEP_W     = 3;

   localparam logic [MV_W-1:0]  RST_FULL_MV     = 12'd3000;
   localparam logic [MV_W-1:0]  RST_LOW_MV      = 12'd2500;
   localparam logic [MV_W-1:0]  RST_CRITICAL_MV = 12'd2200;
   localparam logic [MV_W-1:0]  RST_SHUTDOWN_MV = 12'd2000;
   localparam logic [CNT_W-1:0] RST_CHECK_S     = 16'd60;
   localparam logic [CNT_W-1:0] RST_IDLE_S      = 16'd300;
   localparam logic [CNT_W-1:0] RST_DEEP_S      = 16'd1800;

   typedef enum logic [1:0] {
      MODE_ACTIVE = 2'd0,
      MODE_LOW    = 2'd1,
      MODE_SLEEP  = 2'd2,
      MODE_DEEP   = 2'd3
   } mode_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK       = 2'd0,
      FUNC_ACTIVITY   = 2'd1,
      FUNC_DISCONNECT = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULL_MV      = 3'd0,
      CSR_LOW_MV       = 3'd1,
      CSR_CRITICAL_MV  = 3'd2,
      CSR_SHUTDOWN_MV  = 3'd3,
      CSR_CHECK_S      = 3'd4,
      CSR_IDLE_S       = 3'd5,
      CSR_DEEP_S       = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CONV,
      ST_DIV,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [MV_W-1:0]  full_mv;
      logic [MV_W-1:0]  low_mv;
      logic [MV_W-1:0]  critical_mv;
      logic [MV_W-1:0]  shutdown_mv;
      logic [CNT_W-1:0] check_interval_s;
      logic [CNT_W-1:0] idle_timeout_s;
      logic [CNT_W-1:0] deep_sleep_timeout_s;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== sv/bpm_if.sv =====
// Request and response channel interfaces of the power mode controller.
interface bpm_req_if;
   logic                        valid;
   logic                        ready;
   logic [bpm_pkg::FUNC_W-1:0]  func;
   logic signed [bpm_pkg::SMP_W-1:0] adc_sample;
   logic                        adc_ok;

   modport source (output valid, func, adc_sample, adc_ok, input ready);
   modport sink   (input valid, func, adc_sample, adc_ok, output ready);
endinterface

interface bpm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  power_mode;
   logic                        mode_changed;
   logic [bpm_pkg::MV_W-1:0]    battery_mv;
   logic [bpm_pkg::PCT_W-1:0]   charge_percent;
   logic                        is_low;
   logic                        battery_critical;
   logic [bpm_pkg::CNT_W-1:0]   idle_seconds;
   logic                        took_reading;
   logic                        system_off;

   modport source (output valid, power_mode, mode_changed, battery_mv, charge_percent,
                   is_low, battery_critical, idle_seconds, took_reading, system_off,
                   input ready);
   modport sink   (input valid, power_mode, mode_changed, battery_mv, charge_percent,
                   is_low, battery_critical, idle_seconds, took_reading, system_off,
                   output ready);
endinterface

// ===== sv/bpm_div.sv =====
// Shift-subtract divider that yields the charge percentage one bit a cycle.
module bpm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bpm_pkg::NUM_W-1:0]    num,
   input  logic [bpm_pkg::MV_W-1:0]     den,
   output bpm_pkg::div_stat_type        stat,
   output logic [bpm_pkg::QUO_W-1:0]    quo
);
   import bpm_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   dvs_ff, dvs_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic               ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      ge      = rem_ff >= dvs_ff;
      if (start) begin
         // align divisor with the top quotient bit
         rem_in  = num;
         dvs_in  = NUM_W'(den) << (QUO_W - 1);
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dvs_ff;
         end
         quo_in = {quo_ff[QUO_W-2:0], ge};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign stat = div_stat_type'{busy: busy_ff, done: done_ff};
   assign quo  = quo_ff;

endmodule

// ===== sv/bpm_mode.sv =====
// Power mode selection from battery voltage, link state and idle time.
module bpm_mode (
   input  bpm_pkg::cfg_type             cfg,
   input  logic [bpm_pkg::MV_W-1:0]     volts,
   input  logic                         link_up,
   input  logic [bpm_pkg::CNT_W-1:0]    idle_count,
   input  bpm_pkg::mode_type            cur_mode,
   output bpm_pkg::mode_type            nxt_mode
);
   import bpm_pkg::*;

   always_comb begin
      nxt_mode = cur_mode;
      if (volts <= cfg.shutdown_mv) begin
         nxt_mode = MODE_DEEP;
      end else if (volts <= cfg.critical_mv) begin
         nxt_mode = MODE_SLEEP;
      end else if (volts <= cfg.low_mv && !link_up) begin
         nxt_mode = MODE_LOW;
      end
      // healthy battery: idle timers or the link decide
      if (volts > cfg.low_mv) begin
         if (!link_up && idle_count >= cfg.deep_sleep_timeout_s) begin
            nxt_mode = MODE_DEEP;
         end else if (!link_up && idle_count >= cfg.idle_timeout_s) begin
            nxt_mode = MODE_SLEEP;
         end else if (link_up) begin
            nxt_mode = MODE_ACTIVE;
         end
      end
   end

endmodule

// ===== sv/battery_idle_power_mode_controller_unit.sv =====
// Battery and idle power mode controller: one request at a time through a small
// sequencer. An activity, disconnect, unused or halted request goes from acceptance
// through the exec and finish states back to ready; a tick without a battery reading,
// or with a bad sample, also passes the decide state; a tick with a good sample adds
// the conv state, and when the charge lies between the shutdown and full thresholds
// also the div state, because the percentage then goes through the divider at one
// quotient bit per cycle. A request is worked on while the previous response still
// waits in the output register, and holds in its finish state until that response
// is taken. Once deep sleep is entered every request is answered with the held
// values and system_off set, until reset. The user must write registers through
// the csr port only while no request is in flight; the block does not enforce it.
`include "assert_macros.svh"

module battery_idle_power_mode_controller_unit (
   input  logic                              clock,
   input  logic                              reset,
   bpm_req_if.sink                           req_ch,
   bpm_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [bpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bpm_pkg::*;

   state_type          state_ff, state_in;
   cfg_type            cfg_ff, cfg_in;
   mode_type           mode_ff, mode_in;
   logic               link_ff, link_in;
   logic [CNT_W-1:0]   idle_ff, idle_in;
   logic [CNT_W-1:0]   check_ff, check_in;
   logic [MV_W-1:0]    volts_ff, volts_in;
   logic [PCT_W-1:0]   pct_ff, pct_in;
   logic               low_ff, low_in;
   logic               crit_ff, crit_in;
   logic               first_ff, first_in;
   logic               took_ff, took_in;
   logic               chg_ff, chg_in;

   logic [FUNC_W-1:0]       func_ff, func_in;
   logic signed [SMP_W-1:0] smp_ff, smp_in;
   logic                    ok_ff, ok_in;
   logic [MV_W-1:0]         mv_ff, mv_in;

   logic               rsp_valid_ff, rsp_valid_in;
   mode_type           rsp_mode_ff, rsp_mode_in;
   logic               rsp_chg_ff, rsp_chg_in;
   logic [MV_W-1:0]    rsp_mv_ff, rsp_mv_in;
   logic [PCT_W-1:0]   rsp_pct_ff, rsp_pct_in;
   logic               rsp_low_ff, rsp_low_in;
   logic               rsp_crit_ff, rsp_crit_in;
   logic [CNT_W-1:0]   rsp_idle_ff, rsp_idle_in;
   logic               rsp_took_ff, rsp_took_in;

   logic               req_fire;
   logic [MV_W-1:0]    adc_mag;
   logic [PROD_W-1:0]  prod;
   logic [CNT_W-1:0]   check_inc;
   logic               take;
   logic               div_start;
   logic [NUM_W-1:0]   div_num;
   logic [MV_W-1:0]    div_den;
   div_stat_type       div_stat;
   logic [QUO_W-1:0]   div_quo;
   mode_type           nxt_mode;

   bpm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   bpm_mode u_mode (
      .cfg        (cfg_ff),
      .volts      (volts_ff),
      .link_up    (link_ff),
      .idle_count (idle_ff),
      .cur_mode   (mode_ff),
      .nxt_mode   (nxt_mode)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= '{full_mv: RST_FULL_MV, low_mv: RST_LOW_MV,
                           critical_mv: RST_CRITICAL_MV, shutdown_mv: RST_SHUTDOWN_MV,
                           check_interval_s: RST_CHECK_S, idle_timeout_s: RST_IDLE_S,
                           deep_sleep_timeout_s: RST_DEEP_S};
         mode_ff      <= MODE_ACTIVE;
         link_ff      <= 1'b0;
         idle_ff      <= '0;
         check_ff     <= '0;
         volts_ff     <= '0;
         pct_ff       <= '0;
         low_ff       <= 1'b0;
         crit_ff      <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         mode_ff      <= mode_in;
         link_ff      <= link_in;
         idle_ff      <= idle_in;
         check_ff     <= check_in;
         volts_ff     <= volts_in;
         pct_ff       <= pct_in;
         low_ff       <= low_in;
         crit_ff      <= crit_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      took_ff     <= took_in;
      chg_ff      <= chg_in;
      func_ff     <= func_in;
      smp_ff      <= smp_in;
      ok_ff       <= ok_in;
      mv_ff       <= mv_in;
      rsp_mode_ff <= rsp_mode_in;
      rsp_chg_ff  <= rsp_chg_in;
      rsp_mv_ff   <= rsp_mv_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_crit_ff <= rsp_crit_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_took_ff <= rsp_took_in;
   end

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FULL_MV:     cfg_in.full_mv              = csr_wdata[MV_W-1:0];
            CSR_LOW_MV:      cfg_in.low_mv               = csr_wdata[MV_W-1:0];
            CSR_CRITICAL_MV: cfg_in.critical_mv          = csr_wdata[MV_W-1:0];
            CSR_SHUTDOWN_MV: cfg_in.shutdown_mv          = csr_wdata[MV_W-1:0];
            CSR_CHECK_S:     cfg_in.check_interval_s     = csr_wdata[CNT_W-1:0];
            CSR_IDLE_S:      cfg_in.idle_timeout_s       = csr_wdata[CNT_W-1:0];
            CSR_DEEP_S:      cfg_in.deep_sleep_timeout_s = csr_wdata[CNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_fire  = req_ch.valid && req_ch.ready;
   // negative samples read as zero
   assign adc_mag   = smp_ff[SMP_W-1] ? '0 : smp_ff[MV_W-1:0];
   assign prod      = PROD_W'(adc_mag) * PROD_W'(MV_SCALE);
   assign check_inc = (check_ff == {CNT_W{1'b1}}) ? check_ff : check_ff + CNT_W'(1);
   assign take      = !first_ff || (check_inc >= cfg_ff.check_interval_s);
   assign div_num   = NUM_W'(mv_ff - cfg_ff.shutdown_mv) * NUM_W'(PCT_FULL);
   assign div_den   = cfg_ff.full_mv - cfg_ff.shutdown_mv;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      link_in      = link_ff;
      idle_in      = idle_ff;
      check_in     = check_ff;
      volts_in     = volts_ff;
      pct_in       = pct_ff;
      low_in       = low_ff;
      crit_in      = crit_ff;
      first_in     = first_ff;
      took_in      = took_ff;
      chg_in       = chg_ff;
      func_in      = func_ff;
      smp_in       = smp_ff;
      ok_in        = ok_ff;
      mv_in        = mv_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_mode_in  = rsp_mode_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_mv_in    = rsp_mv_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_crit_in  = rsp_crit_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_took_in  = rsp_took_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in  = req_ch.func;
               smp_in   = req_ch.adc_sample;
               ok_in    = req_ch.adc_ok;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            took_in  = 1'b0;
            chg_in   = 1'b0;
            state_in = ST_FINISH;
            if (mode_ff != MODE_DEEP) begin
               case (func_ff)
                  FUNC_TICK: begin
                     if (!link_ff && idle_ff != {CNT_W{1'b1}}) begin
                        idle_in = idle_ff + CNT_W'(1);
                     end
                     state_in = ST_DECIDE;
                     if (take) begin
                        check_in = '0;
                        first_in = 1'b1;
                        took_in  = 1'b1;
                        mv_in    = prod[PROD_W-1:ADC_SHIFT];
                        // a bad sample keeps the held reading
                        if (ok_ff) begin
                           state_in = ST_CONV;
                        end
                     end else begin
                        check_in = check_inc;
                     end
                  end
                  FUNC_ACTIVITY: begin
                     link_in = 1'b1;
                     idle_in = '0;
                     if (mode_ff != MODE_ACTIVE && volts_ff > cfg_ff.critical_mv) begin
                        mode_in = MODE_ACTIVE;
                        chg_in  = 1'b1;
                     end
                  end
                  FUNC_DISCONNECT: begin
                     link_in = 1'b0;
                     idle_in = '0;
                  end
                  default: begin
                     link_in = link_ff;
                  end
               endcase
            end
         end
         ST_CONV: begin
            volts_in = mv_ff;
            low_in   = mv_ff <= cfg_ff.low_mv;
            crit_in  = mv_ff <= cfg_ff.critical_mv;
            state_in = ST_DECIDE;
            if (mv_ff >= cfg_ff.full_mv) begin
               pct_in = PCT_W'(PCT_FULL);
            end else if (mv_ff <= cfg_ff.shutdown_mv) begin
               pct_in = '0;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               pct_in   = div_quo;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            mode_in  = nxt_mode;
            chg_in   = nxt_mode != mode_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the response register frees up
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mode_in  = mode_ff;
               rsp_chg_in   = chg_ff;
               rsp_mv_in    = volts_ff;
               rsp_pct_in   = pct_ff;
               rsp_low_in   = low_ff;
               rsp_crit_in  = crit_ff;
               rsp_idle_in  = idle_ff;
               rsp_took_in  = took_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready            = state_ff == ST_IDLE;
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.power_mode       = rsp_mode_ff;
   assign rsp_ch.mode_changed     = rsp_chg_ff;
   assign rsp_ch.battery_mv       = rsp_mv_ff;
   assign rsp_ch.charge_percent   = rsp_pct_ff;
   assign rsp_ch.is_low           = rsp_low_ff;
   assign rsp_ch.battery_critical = rsp_crit_ff;
   assign rsp_ch.idle_seconds     = rsp_idle_ff;
   assign rsp_ch.took_reading     = rsp_took_ff;
   assign rsp_ch.system_off       = rsp_mode_ff == MODE_DEEP;

   `BPM_ASSERT_NEXT(a_deep_sticky, mode_ff == MODE_DEEP, mode_ff == MODE_DEEP, "deep sleep left")
   `BPM_ASSERT_NOW(a_link_idle, link_ff, idle_ff == '0, "idle count running with link up")
   `BPM_ASSERT_NOW(a_div_owner, div_stat.busy || div_stat.done, state_ff == ST_DIV, "divider busy")
   `BPM_ASSERT_NEXT(a_rsp_load, !rsp_valid_ff && rsp_valid_in, state_ff == ST_IDLE, "rsp load")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the battery and idle power mode controller.
`timescale 1ns / 100ps

module testbench;
   import bpm_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int                SETTLE_CYCLES = 24;
   localparam int                RANDOM_PER_SETTING = 60;
   localparam int                PARK_TICKS = 30;

   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic signed [SMP_W-1:0] adc_sample;
      logic                    adc_ok;
   } pm_request_type;

   typedef struct packed {
      logic [1:0]       power_mode;
      logic             mode_changed;
      logic [MV_W-1:0]  battery_mv;
      logic [PCT_W-1:0] charge_percent;
      logic             is_low;
      logic             battery_critical;
      logic [CNT_W-1:0] idle_seconds;
      logic             took_reading;
      logic             system_off;
   } pm_status_type;

   typedef struct {
      mode_type         mode;
      logic             link;
      logic [CNT_W-1:0] idle_cnt;
      logic [CNT_W-1:0] check_cnt;
      logic [MV_W-1:0]  mv;
      logic [PCT_W-1:0] pct;
      logic             low;
      logic             crit;
      logic             seen;
   } ctl_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bpm_req_if req_ch ();
   bpm_rsp_if rsp_ch ();

   battery_idle_power_mode_controller_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // controller state and thresholds as the testbench sees them
   cfg_type thr = '{RST_FULL_MV, RST_LOW_MV, RST_CRITICAL_MV, RST_SHUTDOWN_MV,
                    RST_CHECK_S, RST_IDLE_S, RST_DEEP_S};
   ctl_state_type ctl = '{MODE_ACTIVE, 1'b0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0};

   pm_request_type queued_requests[$];
   pm_status_type  predicted_status[$];

   bit bursty = 1'b1;
   bit calm = 1'b0;
   int send_gap = 0;
   int hold_gap = 0;
   int mismatch_count = 0;
   int responses_seen = 0;
   int readings_seen = 0;
   int mode_changes_seen = 0;
   int halted_seen = 0;
   int settings_used = 1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic pm_status_type predict_power_status(pm_request_type rq);
      pm_status_type st;
      mode_type      next_mode;
      int unsigned   s, mv;
      st.mode_changed = 1'b0;
      st.took_reading = 1'b0;
      if (ctl.mode != MODE_DEEP) begin
         case (rq.func)
            FUNC_TICK: begin
               if (!ctl.link && ctl.idle_cnt != 16'hFFFF) ctl.idle_cnt++;
               if (ctl.check_cnt != 16'hFFFF) ctl.check_cnt++;
               if (!ctl.seen || ctl.check_cnt >= thr.check_interval_s) begin
                  ctl.check_cnt = '0;
                  ctl.seen = 1'b1;
                  st.took_reading = 1'b1;
                  // a bad sample still counts as a reading but keeps the old values
                  if (rq.adc_ok) begin
                     s = rq.adc_sample[SMP_W-1] ? 0 : rq.adc_sample[MV_W-1:0];
                     mv = (s * MV_SCALE) >> ADC_SHIFT;
                     ctl.mv = mv[MV_W-1:0];
                     if (mv >= thr.full_mv)
                        ctl.pct = PCT_W'(PCT_FULL);
                     else if (mv <= thr.shutdown_mv)
                        ctl.pct = '0;
                     else
                        ctl.pct = PCT_W'(((mv - thr.shutdown_mv) * PCT_FULL) /
                                         (thr.full_mv - thr.shutdown_mv));
                     ctl.low = (mv <= thr.low_mv);
                     ctl.crit = (mv <= thr.critical_mv);
                  end
               end
               next_mode = ctl.mode;
               if (ctl.mv <= thr.shutdown_mv)
                  next_mode = MODE_DEEP;
               else if (ctl.mv <= thr.critical_mv)
                  next_mode = MODE_SLEEP;
               else if (ctl.mv <= thr.low_mv && !ctl.link)
                  next_mode = MODE_LOW;
               if (ctl.mv > thr.low_mv) begin
                  if (!ctl.link && ctl.idle_cnt >= thr.deep_sleep_timeout_s)
                     next_mode = MODE_DEEP;
                  else if (!ctl.link && ctl.idle_cnt >= thr.idle_timeout_s)
                     next_mode = MODE_SLEEP;
                  else if (ctl.link)
                     next_mode = MODE_ACTIVE;
               end
               if (next_mode != ctl.mode) begin
                  ctl.mode = next_mode;
                  st.mode_changed = 1'b1;
               end
            end
            FUNC_ACTIVITY: begin
               ctl.link = 1'b1;
               ctl.idle_cnt = '0;
               if (ctl.mode != MODE_ACTIVE && ctl.mv > thr.critical_mv) begin
                  ctl.mode = MODE_ACTIVE;
                  st.mode_changed = 1'b1;
               end
            end
            FUNC_DISCONNECT: begin
               ctl.link = 1'b0;
               ctl.idle_cnt = '0;
            end
            default: ;
         endcase
      end
      st.power_mode = ctl.mode;
      st.battery_mv = ctl.mv;
      st.charge_percent = ctl.pct;
      st.is_low = ctl.low;
      st.battery_critical = ctl.crit;
      st.idle_seconds = ctl.idle_cnt;
      st.system_off = (ctl.mode == MODE_DEEP);
      return st;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      mismatch_count++;
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
   endtask

   // request driver: hold valid until accepted, idle in bursts between requests
   always @(posedge clock) begin
      logic drive;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         drive = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            predicted_status.push_back(predict_power_status(queued_requests.pop_front()));
            drive = 1'b0;
         end
         if (!drive) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (bursty && !calm && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 10) - 1;
            end else if (queued_requests.size() != 0) begin
               drive = 1'b1;
               req_ch.func <= queued_requests[0].func;
               req_ch.adc_sample <= queued_requests[0].adc_sample;
               req_ch.adc_ok <= queued_requests[0].adc_ok;
            end
         end
         req_ch.valid <= drive;
      end
   end

   // response monitor: compare against the oldest prediction, stall in bursts
   always @(posedge clock) begin
      logic          take;
      pm_status_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_status.size() == 0) begin
               report_mismatch("response with nothing outstanding", rsp_ch.power_mode, '0);
            end else begin
               want = predicted_status.pop_front();
               responses_seen++;
               readings_seen += want.took_reading;
               mode_changes_seen += want.mode_changed;
               halted_seen += want.system_off;
               if (rsp_ch.power_mode !== want.power_mode)
                  report_mismatch("power_mode", rsp_ch.power_mode, want.power_mode);
               if (rsp_ch.mode_changed !== want.mode_changed)
                  report_mismatch("mode_changed", rsp_ch.mode_changed, want.mode_changed);
               if (rsp_ch.battery_mv !== want.battery_mv)
                  report_mismatch("battery_mv", rsp_ch.battery_mv, want.battery_mv);
               if (rsp_ch.charge_percent !== want.charge_percent)
                  report_mismatch("charge_percent", rsp_ch.charge_percent,
                                  want.charge_percent);
               if (rsp_ch.is_low !== want.is_low)
                  report_mismatch("is_low", rsp_ch.is_low, want.is_low);
               if (rsp_ch.battery_critical !== want.battery_critical)
                  report_mismatch("battery_critical", rsp_ch.battery_critical,
                                  want.battery_critical);
               if (rsp_ch.idle_seconds !== want.idle_seconds)
                  report_mismatch("idle_seconds", rsp_ch.idle_seconds, want.idle_seconds);
               if (rsp_ch.took_reading !== want.took_reading)
                  report_mismatch("took_reading", rsp_ch.took_reading, want.took_reading);
               if (rsp_ch.system_off !== want.system_off)
                  report_mismatch("system_off", rsp_ch.system_off, want.system_off);
            end
         end
         if (hold_gap > 0) begin
            hold_gap--;
            take = 1'b0;
         end else if (bursty && !calm && $urandom_range(0, 7) == 0) begin
            hold_gap = $urandom_range(1, 10) - 1;
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
         rsp_ch.ready <= take;
      end
   end

   task automatic write_csr(csr_idx_type idx, int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_FULL_MV:     thr.full_mv = value[MV_W-1:0];
         CSR_LOW_MV:      thr.low_mv = value[MV_W-1:0];
         CSR_CRITICAL_MV: thr.critical_mv = value[MV_W-1:0];
         CSR_SHUTDOWN_MV: thr.shutdown_mv = value[MV_W-1:0];
         CSR_CHECK_S:     thr.check_interval_s = value[CNT_W-1:0];
         CSR_IDLE_S:      thr.idle_timeout_s = value[CNT_W-1:0];
         CSR_DEEP_S:      thr.deep_sleep_timeout_s = value[CNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_thresholds(int full_t, int low_t, int crit_t, int sd_t,
                                     int chk_t, int idle_t, int deep_t);
      write_csr(CSR_FULL_MV, full_t);
      write_csr(CSR_LOW_MV, low_t);
      write_csr(CSR_CRITICAL_MV, crit_t);
      write_csr(CSR_SHUTDOWN_MV, sd_t);
      write_csr(CSR_CHECK_S, chk_t);
      write_csr(CSR_IDLE_S, idle_t);
      write_csr(CSR_DEEP_S, deep_t);
      settings_used++;
   endtask

   // wait until the block has answered everything and gone quiet
   task automatic settle();
      while (queued_requests.size() != 0 || req_ch.valid || predicted_status.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic enqueue_request(logic [FUNC_W-1:0] f, int smp, bit ok);
      pm_request_type rq;
      rq.func = f;
      rq.adc_sample = smp[SMP_W-1:0];
      rq.adc_ok = ok;
      queued_requests.push_back(rq);
   endtask

   // smallest sample that converts to at least the given voltage
   function automatic int sample_for_mv(int mv);
      int s;
      s = ((mv << ADC_SHIFT) + MV_SCALE - 1) / MV_SCALE;
      if (s > (1 << ADC_SHIFT) - 1) s = (1 << ADC_SHIFT) - 1;
      if (s < 0) s = 0;
      return s;
   endfunction

   // good samples on ticks always read above shutdown, so the block stays awake
   task automatic enqueue_random_request(bit allow_disconnect);
      int               pick, smp, target, floor_smp;
      logic [FUNC_W-1:0] f;
      bit               ok;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         f = FUNC_TICK;
      else if (pick < 75 || (pick < 90 && !allow_disconnect))
         f = FUNC_ACTIVITY;
      else if (pick < 90)
         f = FUNC_DISCONNECT;
      else
         f = FUNC_UNUSED;
      ok = ($urandom_range(0, 4) != 0);
      if (f == FUNC_TICK && ok) begin
         floor_smp = sample_for_mv(thr.shutdown_mv + 1);
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
               0: target = thr.critical_mv;
               1: target = thr.critical_mv + 1;
               2: target = thr.low_mv;
               3: target = thr.low_mv + 1;
               4: target = thr.full_mv;
               default: target = int'(thr.full_mv) - 1;
            endcase
            smp = sample_for_mv(target);
         end else begin
            smp = $urandom_range(0, 4095);
         end
         if (smp < floor_smp) smp = floor_smp;
      end else begin
         smp = int'($urandom_range(0, 6143)) - 2048;
      end
      enqueue_request(f, smp, ok);
   endtask

   initial begin
      int sd_t, crit_t, low_t, full_t, chk_t, idle_t, deep_t;
      int lo_smp, hi_smp;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_TICK;
      req_ch.adc_sample = '0;
      req_ch.adc_ok = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_FULL_MV;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset thresholds: first-tick reading, unused code, link events, bad sample
      enqueue_request(FUNC_TICK, 3000, 1'b1);
      enqueue_request(FUNC_UNUSED, 4095, 1'b1);
      enqueue_request(FUNC_ACTIVITY, -2048, 1'b1);
      enqueue_request(FUNC_TICK, 4095, 1'b1);
      enqueue_request(FUNC_TICK, -1, 1'b0);
      enqueue_request(FUNC_DISCONNECT, 0, 1'b0);
      enqueue_request(FUNC_TICK, 2500, 1'b1);
      settle();
      // lower the interval below the running count: next tick reads at once
      write_csr(CSR_CHECK_S, 2);
      enqueue_request(FUNC_TICK, 4095, 1'b1);
      enqueue_request(FUNC_TICK, 3414, 1'b1);
      enqueue_request(FUNC_TICK, 3414, 1'b1);
      enqueue_request(FUNC_TICK, 2400, 1'b1);
      enqueue_request(FUNC_TICK, 2400, 1'b1);
      enqueue_request(FUNC_ACTIVITY, 100, 1'b0);
      enqueue_request(FUNC_TICK, 2800, 1'b1);
      enqueue_request(FUNC_TICK, 2800, 1'b1);
      enqueue_request(FUNC_ACTIVITY, 0, 1'b1);
      enqueue_request(FUNC_DISCONNECT, -2048, 1'b1);
      enqueue_request(FUNC_TICK, -2048, 1'b0);
      enqueue_request(FUNC_TICK, -2048, 1'b0);
      enqueue_request(FUNC_TICK, 2900, 1'b1);
      enqueue_request(FUNC_TICK, 2278, 1'b1);
      enqueue_request(FUNC_UNUSED, -1, 1'b0);
      settle();

      for (int p = 0; p < 8; p++) begin
         sd_t = $urandom_range(0, 400);
         // keep the held reading above shutdown so a bad sample cannot halt the block
         if (ctl.mv != '0 && sd_t >= int'(ctl.mv)) sd_t = int'(ctl.mv) - 1;
         chk_t = $urandom_range(1, 4);
         idle_t = $urandom_range(0, 30);
         deep_t = $urandom_range(1000, 65535);
         case (p)
            0: begin
               full_t = 4095; low_t = 4095; crit_t = 4095;
               chk_t = 1; idle_t = 65535; deep_t = 65535;
            end
            1: begin
               full_t = 0; low_t = 0; crit_t = 0; sd_t = 0;
               chk_t = 1; idle_t = 0; deep_t = 65535;
            end
            3: begin
               full_t = $urandom_range(0, 4095);
               low_t = $urandom_range(0, 4095);
               crit_t = $urandom_range(0, 4095);
               chk_t = 0;
            end
            default: begin
               crit_t = $urandom_range(sd_t + 1, 2600);
               low_t = $urandom_range(crit_t, 3100);
               full_t = $urandom_range(low_t, 4095);
               if (p == 2) chk_t = 1;
            end
         endcase
         // a zero deep-sleep timeout is only safe while the link stays up
         if (p == 2) deep_t = 0;
         program_thresholds(full_t, low_t, crit_t, sd_t, chk_t, idle_t, deep_t);
         bursty = (p != 5);
         if (p == 2) enqueue_request(FUNC_ACTIVITY, 0, 1'b0);
         repeat (RANDOM_PER_SETTING) enqueue_random_request(p != 2);
         settle();
      end

      // park in low power and tick back to back with no idling
      calm = 1'b1;
      program_thresholds(3000, 2000, 1000, 100, 1, 300, 65535);
      enqueue_request(FUNC_DISCONNECT, 0, 1'b0);
      enqueue_request(FUNC_TICK, sample_for_mv(1500), 1'b1);
      settle();
      write_csr(CSR_CHECK_S, 65535);
      lo_smp = sample_for_mv(1100);
      hi_smp = sample_for_mv(1900);
      repeat (PARK_TICKS)
         enqueue_request(FUNC_TICK, int'($urandom_range(lo_smp, hi_smp)),
                         1'($urandom_range(0, 1)));
      settle();

      // clamped negative sample under the top shutdown level: deep sleep, then halt
      write_csr(CSR_SHUTDOWN_MV, 4095);
      write_csr(CSR_CHECK_S, 0);
      enqueue_request(FUNC_TICK, -2048, 1'b1);
      repeat (8)
         enqueue_request(FUNC_W'($urandom_range(0, 3)), int'($urandom_range(0, 6143)) - 2048,
                         1'($urandom_range(0, 1)));
      settle();

      $display("covered %0d requests over %0d threshold settings: %0d battery readings,",
               responses_seen, settings_used, readings_seen);
      $display("%0d mode changes, a parked low power stretch and %0d requests answered halted",
               mode_changes_seen, halted_seen);
      if (mismatch_count == 0 && predicted_status.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bpm_pkg.sv
sv/bpm_if.sv
sv/bpm_div.sv
sv/bpm_mode.sv
sv/battery_idle_power_mode_controller_unit.sv
tb/testbench.sv
